FILE: rtl/sbua_pkg.sv
// Package for the single-block uplink allocator.
// Holds request and response transaction types, request and status codes and frame constants.
// Depends on nothing.
package sbua_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int NUM_TRX_DEF     = 8;

  localparam int FRAME_W   = 22;
  localparam int CHAN_NUM  = 64;
  localparam int TA_W      = 6;
  localparam int FREED_W   = 5;

  localparam logic [FRAME_W-1:0] HYPERFRAME   = 22'd2715648;
  localparam logic [FRAME_W:0]   START_OFFSET = 23'd52;
  localparam logic [FRAME_W:0]   QUERY_OFFSET = 23'd4;
  localparam logic [7:0]         TA_MAX       = 8'd63;
  localparam logic [FREED_W-1:0] FREED_MAX    = 5'd31;

  localparam logic [2:0] REQ_ALLOC      = 3'd0;
  localparam logic [2:0] REQ_QUERY      = 3'd1;
  localparam logic [2:0] REQ_FREE_MATCH = 3'd2;
  localparam logic [2:0] REQ_FREE_CHAN  = 3'd3;
  localparam logic [2:0] REQ_RECORD     = 3'd4;

  localparam logic [2:0] STAT_OK        = 3'd0;
  localparam logic [2:0] STAT_BAD_TA    = 3'd1;
  localparam logic [2:0] STAT_NO_CHAN   = 3'd2;
  localparam logic [2:0] STAT_FULL      = 3'd3;
  localparam logic [2:0] STAT_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [2:0]         trx_index;
    logic [2:0]         slot_index;
    logic [FRAME_W-1:0] frame_number;
    logic [3:0]         block_number;
    logic [7:0]         timing_advance;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         granted_trx;
    logic [2:0]         granted_slot;
    logic [FRAME_W-1:0] result_frame;
    logic [FREED_W-1:0] freed_count;
  } rsp_t;

  typedef struct packed {
    logic [TA_W-1:0]    ta;
    logic [2:0]         trx;
    logic [2:0]         slot;
    logic [FRAME_W-1:0] frame;
  } grant_t;

  localparam int GRANT_W = $bits(grant_t);

endpackage

FILE: rtl/sbua_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the grant table and the ready-to-send frame store. No dependencies.
module sbua_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/single_block_uplink_allocator.sv
// Single-block uplink allocator top level: grant table in RAM, request sequencer.
// Depends on sbua_pkg and sbua_ram.
// Record, bad timing advance and unknown requests: result in the cycle after accept, busy stays low.
// Table requests scan one grant entry per cycle through the grant RAM read port; busy until
// the result shows (free channel always scans every entry of the table).
// Reset clears grant valid bits, frame store valid bits and the enable mask; no clearing pass.
// Each result shows for one cycle with out_valid; the receiver cannot stall.
module single_block_uplink_allocator #(
  parameter int TABLE_DEPTH = sbua_pkg::TABLE_DEPTH_DEF,
  parameter int NUM_TRX     = sbua_pkg::NUM_TRX_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  sbua_pkg::req_t in_req,
  output logic           out_valid,
  output sbua_pkg::rsp_t out_rsp,
  input  logic           cfg_wr_en,
  input  logic [63:0]    cfg_wr_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CH_W  = $clog2(sbua_pkg::CHAN_NUM);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } fsm_state_t;

  fsm_state_t                          state_r, state_nxt;
  logic [2:0]                          op_r, op_nxt;
  logic [2:0]                          trx_r, trx_nxt;
  logic [2:0]                          slot_r, slot_nxt;
  logic [sbua_pkg::TA_W-1:0]           ta_r, ta_nxt;
  logic [sbua_pkg::FRAME_W-1:0]        frame_r, frame_nxt;
  logic [IDX_W-1:0]                    scan_idx_r, scan_idx_nxt;
  logic                                issue_done_r, issue_done_nxt;
  logic                                chk_vld_r, chk_vld_nxt;
  logic [IDX_W-1:0]                    chk_idx_r, chk_idx_nxt;
  logic [sbua_pkg::FREED_W-1:0]        freed_r, freed_nxt;
  logic [TABLE_DEPTH-1:0]              gnt_valid_r, gnt_valid_nxt;
  logic [sbua_pkg::CHAN_NUM-1:0]       rts_valid_r, rts_valid_nxt;
  logic                                rts_vld_q_r;
  logic [63:0]                         mask_r;
  logic                                out_valid_r, out_valid_nxt;
  sbua_pkg::rsp_t                      out_rsp_r, out_rsp_nxt;

  logic                                gnt_we;
  sbua_pkg::grant_t                    gnt_wdata;
  logic [sbua_pkg::GRANT_W-1:0]        gnt_rdata;
  sbua_pkg::grant_t                    gnt_rd;
  logic                                rts_we;
  logic [CH_W-1:0]                     rts_wr_addr;
  logic [CH_W-1:0]                     rts_rd_addr;
  logic [sbua_pkg::FRAME_W-1:0]        rts_rdata;

  logic                                chan_found;
  logic [2:0]                          chan_trx;
  logic [2:0]                          chan_slot;
  logic [7:0]                          chan_byte;

  logic                                blk_adj;
  logic [sbua_pkg::FRAME_W:0]          query_sum;
  logic [sbua_pkg::FRAME_W-1:0]        query_frame;
  logic [sbua_pkg::FRAME_W-1:0]        rts_base;
  logic [sbua_pkg::FRAME_W:0]          grant_sum;
  logic [sbua_pkg::FRAME_W-1:0]        grant_frame;
  logic                                chk_match;
  logic                                chk_hit;
  logic                                chk_last;
  logic                                accept;

  sbua_ram #(
    .WIDTH (sbua_pkg::GRANT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_grant_ram (
    .clk     (clk),
    .wr_en   (gnt_we),
    .wr_addr (chk_idx_r),
    .wr_data (gnt_wdata),
    .rd_addr (scan_idx_r),
    .rd_data (gnt_rdata)
  );

  sbua_ram #(
    .WIDTH (sbua_pkg::FRAME_W),
    .DEPTH (sbua_pkg::CHAN_NUM)
  ) u_rts_ram (
    .clk     (clk),
    .wr_en   (rts_we),
    .wr_addr (rts_wr_addr),
    .wr_data (in_req.frame_number),
    .rd_addr (rts_rd_addr),
    .rd_data (rts_rdata)
  );

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;
  assign accept    = start && (state_r == ST_IDLE);
  assign gnt_rd    = sbua_pkg::grant_t'(gnt_rdata);

  // lowest transceiver with any enabled channel, highest slot within it
  always_comb begin
    chan_found = 1'b0;
    chan_trx   = '0;
    chan_byte  = '0;
    chan_slot  = '0;
    for (int t = NUM_TRX - 1; t >= 0; t--) begin
      if (|mask_r[t*8 +: 8]) begin
        chan_found = 1'b1;
        chan_trx   = 3'(t);
        chan_byte  = mask_r[t*8 +: 8];
      end
    end
    for (int s = 0; s < 8; s++) begin
      if (chan_byte[s]) begin
        chan_slot = 3'(s);
      end
    end
  end

  assign rts_rd_addr = {chan_trx, chan_slot};
  assign rts_wr_addr = {in_req.trx_index, in_req.slot_index};

  always_comb begin
    case (in_req.block_number) inside
      4'd2, 4'd5, 4'd8, 4'd11, 4'd14: blk_adj = 1'b1;
      default:                        blk_adj = 1'b0;
    endcase
  end

  assign query_sum   = {1'b0, in_req.frame_number} + sbua_pkg::QUERY_OFFSET
                       + {{sbua_pkg::FRAME_W{1'b0}}, blk_adj};
  assign query_frame = (query_sum >= {1'b0, sbua_pkg::HYPERFRAME})
                       ? sbua_pkg::FRAME_W'(query_sum - {1'b0, sbua_pkg::HYPERFRAME})
                       : query_sum[sbua_pkg::FRAME_W-1:0];

  assign rts_base    = rts_vld_q_r ? rts_rdata : '0;
  assign grant_sum   = {1'b0, rts_base} + sbua_pkg::START_OFFSET;
  assign grant_frame = (grant_sum >= {1'b0, sbua_pkg::HYPERFRAME})
                       ? sbua_pkg::FRAME_W'(grant_sum - {1'b0, sbua_pkg::HYPERFRAME})
                       : grant_sum[sbua_pkg::FRAME_W-1:0];

  assign chk_match = gnt_valid_r[chk_idx_r] && (gnt_rd.trx == trx_r) && (gnt_rd.slot == slot_r)
                     && ((op_r == sbua_pkg::REQ_FREE_CHAN) || (gnt_rd.frame == frame_r));
  assign chk_hit   = (op_r == sbua_pkg::REQ_ALLOC) ? !gnt_valid_r[chk_idx_r] : chk_match;
  assign chk_last  = (chk_idx_r == LAST_IDX);

  assign gnt_wdata = '{ta: ta_r, trx: chan_trx, slot: chan_slot, frame: grant_frame};

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    trx_nxt        = trx_r;
    slot_nxt       = slot_r;
    ta_nxt         = ta_r;
    frame_nxt      = frame_r;
    scan_idx_nxt   = scan_idx_r;
    issue_done_nxt = issue_done_r;
    chk_vld_nxt    = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    freed_nxt      = freed_r;
    gnt_valid_nxt  = gnt_valid_r;
    rts_valid_nxt  = rts_valid_r;
    out_valid_nxt  = 1'b0;
    out_rsp_nxt    = out_rsp_r;
    gnt_we         = 1'b0;
    rts_we         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_nxt         = in_req.req_type;
          trx_nxt        = in_req.trx_index;
          slot_nxt       = in_req.slot_index;
          ta_nxt         = in_req.timing_advance[sbua_pkg::TA_W-1:0];
          frame_nxt      = (in_req.req_type == sbua_pkg::REQ_QUERY)
                           ? query_frame : in_req.frame_number;
          scan_idx_nxt   = '0;
          issue_done_nxt = 1'b0;
          freed_nxt      = '0;
          out_rsp_nxt    = '0;
          unique case (in_req.req_type) inside
            sbua_pkg::REQ_ALLOC: begin
              if (in_req.timing_advance > sbua_pkg::TA_MAX) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = sbua_pkg::STAT_BAD_TA;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            sbua_pkg::REQ_QUERY, sbua_pkg::REQ_FREE_MATCH, sbua_pkg::REQ_FREE_CHAN: begin
              state_nxt = ST_SCAN;
            end
            sbua_pkg::REQ_RECORD: begin
              rts_we                     = 1'b1;
              rts_valid_nxt[rts_wr_addr] = 1'b1;
              out_valid_nxt              = 1'b1;
              out_rsp_nxt.status         = sbua_pkg::STAT_OK;
            end
            default: begin
              out_valid_nxt      = 1'b1;
              out_rsp_nxt.status = sbua_pkg::STAT_NOT_FOUND;
            end
          endcase
        end
      end

      ST_SCAN: begin
        if (!issue_done_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = scan_idx_r;
          if (scan_idx_r == LAST_IDX) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_idx_nxt = scan_idx_r + 1'b1;
          end
        end
        if (chk_vld_r) begin
          out_rsp_nxt = '0;
          unique case (op_r) inside
            sbua_pkg::REQ_ALLOC: begin
              if (chk_hit) begin
                out_valid_nxt = 1'b1;
                if (!chan_found) begin
                  out_rsp_nxt.status = sbua_pkg::STAT_NO_CHAN;
                end else begin
                  gnt_we                    = 1'b1;
                  gnt_valid_nxt[chk_idx_r]  = 1'b1;
                  out_rsp_nxt.status        = sbua_pkg::STAT_OK;
                  out_rsp_nxt.granted_trx   = chan_trx;
                  out_rsp_nxt.granted_slot  = chan_slot;
                  out_rsp_nxt.result_frame  = grant_frame;
                end
              end else if (chk_last) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = sbua_pkg::STAT_FULL;
              end
            end
            sbua_pkg::REQ_QUERY: begin
              if (chk_hit) begin
                out_valid_nxt            = 1'b1;
                out_rsp_nxt.status       = sbua_pkg::STAT_OK;
                out_rsp_nxt.result_frame = frame_r;
              end else if (chk_last) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = sbua_pkg::STAT_NOT_FOUND;
              end
            end
            sbua_pkg::REQ_FREE_MATCH: begin
              if (chk_hit) begin
                gnt_valid_nxt[chk_idx_r] = 1'b0;
                out_valid_nxt            = 1'b1;
                out_rsp_nxt.status       = sbua_pkg::STAT_OK;
                out_rsp_nxt.freed_count  = sbua_pkg::FREED_W'(1);
              end else if (chk_last) begin
                out_valid_nxt      = 1'b1;
                out_rsp_nxt.status = sbua_pkg::STAT_NOT_FOUND;
              end
            end
            default: begin
              if (chk_hit) begin
                gnt_valid_nxt[chk_idx_r] = 1'b0;
                if (freed_r != sbua_pkg::FREED_MAX) begin
                  freed_nxt = freed_r + 1'b1;
                end
              end
              if (chk_last) begin
                out_valid_nxt           = 1'b1;
                out_rsp_nxt.status      = sbua_pkg::STAT_OK;
                out_rsp_nxt.freed_count = freed_nxt;
              end
            end
          endcase
          if (out_valid_nxt) begin
            state_nxt   = ST_IDLE;
            chk_vld_nxt = 1'b0;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_done_r <= 1'b0;
      chk_vld_r    <= 1'b0;
      gnt_valid_r  <= '0;
      rts_valid_r  <= '0;
      rts_vld_q_r  <= 1'b0;
      mask_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      chk_vld_r    <= chk_vld_nxt;
      gnt_valid_r  <= gnt_valid_nxt;
      rts_valid_r  <= rts_valid_nxt;
      rts_vld_q_r  <= rts_valid_r[rts_rd_addr];
      out_valid_r  <= out_valid_nxt;
      if (cfg_wr_en) begin
        mask_r <= cfg_wr_data;
      end
    end
    op_r       <= op_nxt;
    trx_r      <= trx_nxt;
    slot_r     <= slot_nxt;
    ta_r       <= ta_nxt;
    frame_r    <= frame_nxt;
    scan_idx_r <= scan_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    freed_r    <= freed_nxt;
    out_rsp_r  <= out_rsp_nxt;
  end

endmodule

FILE: test/single_block_uplink_allocator_tb.sv
// Testbench for single_block_uplink_allocator: directed requests, then random request traffic.
// Predicts every response from its own grant table and checks each one in arrival order.
// Depends on sbua_pkg and the single_block_uplink_allocator RTL.
module single_block_uplink_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = sbua_pkg::TABLE_DEPTH_DEF;
  localparam int TRX_N = sbua_pkg::NUM_TRX_DEF;
  localparam int SETTLE_CYCLES = DEPTH + 8;
  localparam int CYCLE_LIMIT = 600000;
  localparam int unsigned HF_LEN = 32'(sbua_pkg::HYPERFRAME);
  localparam int unsigned FRAME_TOP = (1 << sbua_pkg::FRAME_W) - 1;
  localparam logic [2:0] REQ_UNKNOWN = sbua_pkg::REQ_RECORD + 3'd1;

  logic                         clk = 1'b0;
  logic                         rst_n;
  logic                         start;
  logic                         busy;
  sbua_pkg::req_t               in_req;
  logic                         out_valid;
  sbua_pkg::rsp_t               out_rsp;
  logic                         cfg_wr_en;
  logic [63:0]                  cfg_wr_data;

  logic [63:0]                  enable_mask;
  bit                           grant_used [DEPTH];
  sbua_pkg::grant_t             grant_tab [DEPTH];
  logic [sbua_pkg::FRAME_W-1:0] rts_frame [sbua_pkg::CHAN_NUM];
  sbua_pkg::rsp_t               rsp_pending [$];
  int                           mismatches;
  bit                           no_idle;

  single_block_uplink_allocator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_valid  (out_valid),
    .out_rsp    (out_rsp),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  function automatic bit lowest_enabled(input logic [63:0] mask, output logic [2:0] trx,
                                        output logic [2:0] slot);
    trx = '0;
    slot = '0;
    for (int t = 0; t < TRX_N; t++) begin
      for (int s = 7; s >= 0; s--) begin
        if (mask[t*8+s]) begin
          trx = 3'(t);
          slot = 3'(s);
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic int find_grant(input logic [2:0] trx, input logic [2:0] slot,
                                    input int unsigned fn);
    for (int i = 0; i < DEPTH; i++) begin
      if (grant_used[i] && grant_tab[i].trx == trx && grant_tab[i].slot == slot &&
          32'(grant_tab[i].frame) == fn) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic sbua_pkg::rsp_t predict_rsp(input sbua_pkg::req_t r);
    sbua_pkg::rsp_t rsp;
    int             free_idx;
    int             k;
    logic [2:0]     ct;
    logic [2:0]     cs;
    int unsigned    q;
    rsp = '0;
    rsp.status = sbua_pkg::STAT_OK;
    case (r.req_type)
      sbua_pkg::REQ_ALLOC: begin
        free_idx = -1;
        for (int i = DEPTH - 1; i >= 0; i--) begin
          if (!grant_used[i]) free_idx = i;
        end
        if (r.timing_advance > sbua_pkg::TA_MAX) begin
          rsp.status = sbua_pkg::STAT_BAD_TA;
        end else if (free_idx < 0) begin
          rsp.status = sbua_pkg::STAT_FULL;
        end else if (!lowest_enabled(enable_mask, ct, cs)) begin
          rsp.status = sbua_pkg::STAT_NO_CHAN;
        end else begin
          q = (32'(rts_frame[{ct, cs}]) + 32'(sbua_pkg::START_OFFSET)) % HF_LEN;
          grant_used[free_idx] = 1'b1;
          grant_tab[free_idx] = '{ta: r.timing_advance[sbua_pkg::TA_W-1:0], trx: ct,
                                  slot: cs, frame: q[sbua_pkg::FRAME_W-1:0]};
          rsp.granted_trx = ct;
          rsp.granted_slot = cs;
          rsp.result_frame = q[sbua_pkg::FRAME_W-1:0];
        end
      end
      sbua_pkg::REQ_QUERY: begin
        q = 32'(r.frame_number) + 32'(sbua_pkg::QUERY_OFFSET)
            + ((r.block_number % 3 == 2) ? 1 : 0);
        q = q % HF_LEN;
        if (find_grant(r.trx_index, r.slot_index, q) >= 0) begin
          rsp.result_frame = q[sbua_pkg::FRAME_W-1:0];
        end else begin
          rsp.status = sbua_pkg::STAT_NOT_FOUND;
        end
      end
      sbua_pkg::REQ_FREE_MATCH: begin
        k = find_grant(r.trx_index, r.slot_index, 32'(r.frame_number));
        if (k >= 0) begin
          grant_used[k] = 1'b0;
          rsp.freed_count = sbua_pkg::FREED_W'(1);
        end else begin
          rsp.status = sbua_pkg::STAT_NOT_FOUND;
        end
      end
      sbua_pkg::REQ_FREE_CHAN: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (grant_used[i] && grant_tab[i].trx == r.trx_index &&
              grant_tab[i].slot == r.slot_index) begin
            grant_used[i] = 1'b0;
            if (rsp.freed_count < sbua_pkg::FREED_MAX)
              rsp.freed_count = rsp.freed_count + 1'b1;
          end
        end
      end
      sbua_pkg::REQ_RECORD: begin
        rts_frame[{r.trx_index, r.slot_index}] = r.frame_number;
      end
      default: begin
        rsp.status = sbua_pkg::STAT_NOT_FOUND;
      end
    endcase
    return rsp;
  endfunction

  function automatic sbua_pkg::req_t mk_req(input logic [2:0] kind, input int trx,
                                            input int slot, input int unsigned fn,
                                            input int blk, input int ta);
    sbua_pkg::req_t r;
    r.req_type = kind;
    r.trx_index = 3'(trx);
    r.slot_index = 3'(slot);
    r.frame_number = sbua_pkg::FRAME_W'(fn);
    r.block_number = 4'(blk);
    r.timing_advance = 8'(ta);
    return r;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 40) return 0;
    if (roll < 82) return $urandom_range(1, 3);
    if (roll < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_grant();
    int idx [$];
    for (int i = 0; i < DEPTH; i++) begin
      if (grant_used[i]) idx.push_back(i);
    end
    if (idx.size() == 0) return -1;
    return idx[$urandom_range(0, idx.size() - 1)];
  endfunction

  function automatic logic [63:0] random_mask();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      4: return {$urandom, $urandom} << (8 * $urandom_range(4, 7));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic sbua_pkg::req_t random_req(input int alloc_weight);
    sbua_pkg::req_t r;
    int             roll;
    int             k;
    logic [2:0]     ct;
    logic [2:0]     cs;
    int unsigned    fn;
    int unsigned    off;
    r = mk_req(sbua_pkg::REQ_RECORD, $urandom_range(0, 7), $urandom_range(0, 7),
               $urandom_range(0, FRAME_TOP), $urandom_range(0, 15), $urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    k = pick_grant();
    if (roll < alloc_weight) begin
      r.req_type = sbua_pkg::REQ_ALLOC;
      if ($urandom_range(0, 99) < 85) r.timing_advance = 8'($urandom_range(0, 63));
    end else if (roll < alloc_weight + 20) begin
      r.req_type = sbua_pkg::REQ_QUERY;
      if (k >= 0 && $urandom_range(0, 9) < 7) begin
        r.trx_index = grant_tab[k].trx;
        r.slot_index = grant_tab[k].slot;
        off = 32'(sbua_pkg::QUERY_OFFSET) + ((r.block_number % 3 == 2) ? 1 : 0);
        fn = 32'(grant_tab[k].frame);
        fn = (fn >= off) ? fn - off : fn + HF_LEN - off;
        if ($urandom_range(0, 4) == 0 && fn + HF_LEN <= FRAME_TOP) fn = fn + HF_LEN;
        r.frame_number = sbua_pkg::FRAME_W'(fn);
      end
    end else if (roll < alloc_weight + 35) begin
      r.req_type = sbua_pkg::REQ_FREE_MATCH;
      if (k >= 0 && $urandom_range(0, 9) < 8) begin
        r.trx_index = grant_tab[k].trx;
        r.slot_index = grant_tab[k].slot;
        fn = 32'(grant_tab[k].frame);
        if ($urandom_range(0, 7) == 0 && fn + HF_LEN <= FRAME_TOP) fn = fn + HF_LEN;
        r.frame_number = sbua_pkg::FRAME_W'(fn);
      end
    end else if (roll < alloc_weight + 42) begin
      r.req_type = sbua_pkg::REQ_FREE_CHAN;
      if (k >= 0 && $urandom_range(0, 9) < 7) begin
        r.trx_index = grant_tab[k].trx;
        r.slot_index = grant_tab[k].slot;
      end
    end else if (roll < alloc_weight + 46) begin
      r.req_type = REQ_UNKNOWN + 3'($urandom_range(0, 2));
    end else begin
      if ($urandom_range(0, 9) < 6 && lowest_enabled(enable_mask, ct, cs)) begin
        r.trx_index = ct;
        r.slot_index = cs;
      end
      case ($urandom_range(0, 2))
        0: r.frame_number = sbua_pkg::FRAME_W'(HF_LEN - $urandom_range(1, 60));
        1: r.frame_number = sbua_pkg::FRAME_W'($urandom_range(0, HF_LEN - 1));
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic send_req(input sbua_pkg::req_t r, input int gap);
    logic [$bits(sbua_pkg::req_t)-1:0] noise;
    if (gap > 0) begin
      noise = $bits(sbua_pkg::req_t)'({$urandom, $urandom});
      @(negedge clk);
      start <= 1'b0;
      in_req <= sbua_pkg::req_t'(noise);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    rsp_pending.push_back(predict_rsp(r));
  endtask

  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (rsp_pending.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_mask(input logic [63:0] value);
    settle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= {$urandom, $urandom};
    enable_mask = value;
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t mismatch %s: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    sbua_pkg::rsp_t want;
    if (rst_n && out_valid) begin
      if (rsp_pending.size() == 0) begin
        note_mismatch("unexpected transaction", '0, 64'(out_rsp));
      end else begin
        want = rsp_pending.pop_front();
        if (out_rsp.status !== want.status)
          note_mismatch("status", 64'(want.status), 64'(out_rsp.status));
        if (out_rsp.granted_trx !== want.granted_trx)
          note_mismatch("granted_trx", 64'(want.granted_trx), 64'(out_rsp.granted_trx));
        if (out_rsp.granted_slot !== want.granted_slot)
          note_mismatch("granted_slot", 64'(want.granted_slot), 64'(out_rsp.granted_slot));
        if (out_rsp.result_frame !== want.result_frame)
          note_mismatch("result_frame", 64'(want.result_frame), 64'(out_rsp.result_frame));
        if (out_rsp.freed_count !== want.freed_count)
          note_mismatch("freed_count", 64'(want.freed_count), 64'(out_rsp.freed_count));
      end
    end
  end

  task automatic test_empty_table();
    send_req(mk_req(sbua_pkg::REQ_ALLOC, 0, 0, 0, 0, 255), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_ALLOC, 7, 7, FRAME_TOP, 15, 0), pick_gap());
    send_req(mk_req(REQ_UNKNOWN + 3'd2, 7, 7, FRAME_TOP, 15, 255), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_QUERY, 7, 7, FRAME_TOP, 15, 64), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_FREE_CHAN, 0, 0, 0, 0, 0), pick_gap());
  endtask

  task automatic test_frame_wrap();
    write_mask('1);
    send_req(mk_req(sbua_pkg::REQ_RECORD, 0, 7, HF_LEN - 1, 0, 0), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_ALLOC, 0, 0, 0, 0, 63), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_QUERY, 0, 7, 47, 0, 0), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_QUERY, 0, 7, 46, 14, 0), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_QUERY, 0, 7, 47, 11, 0), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_RECORD, 0, 7, FRAME_TOP, 0, 0), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_ALLOC, 5, 2, 0, 0, 0), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_FREE_MATCH, 0, 7, 51, 0, 0), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_FREE_MATCH, 0, 7, 51, 0, 0), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_FREE_CHAN, 0, 7, 0, 0, 0), pick_gap());
  endtask

  task automatic test_table_full();
    write_mask(64'd1 << 56);
    repeat (DEPTH) begin
      send_req(mk_req(sbua_pkg::REQ_ALLOC, 0, 0, 0, 0, $urandom_range(0, 63)), pick_gap());
    end
    send_req(mk_req(sbua_pkg::REQ_ALLOC, 0, 0, 0, 0, 200), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_ALLOC, 0, 0, 0, 0, 5), pick_gap());
    write_mask('0);
    send_req(mk_req(sbua_pkg::REQ_ALLOC, 0, 0, 0, 0, 0), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_FREE_CHAN, 7, 0, 0, 0, 0), pick_gap());
    send_req(mk_req(sbua_pkg::REQ_ALLOC, 0, 0, 0, 0, 0), pick_gap());
  endtask

  task automatic test_random_traffic();
    int alloc_weight;
    for (int phase = 0; phase < 18; phase++) begin
      write_mask(random_mask());
      no_idle = ($urandom_range(0, 3) == 0);
      alloc_weight = $urandom_range(15, 40);
      repeat (50) send_req(random_req(alloc_weight), pick_gap());
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_req = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    enable_mask = '0;
    mismatches = 0;
    no_idle = 1'b0;
    for (int i = 0; i < DEPTH; i++) grant_used[i] = 1'b0;
    for (int i = 0; i < sbua_pkg::CHAN_NUM; i++) rts_frame[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_frame_wrap();
    test_table_full();
    test_random_traffic();
    settle();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

endmodule
